>>> hw/rtl/pli_pkg.sv
`default_nettype none

package pli_pkg;

  // Default sizes of the breakpoint table and of its data.
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_DATA_WIDTH = 16;

  // Fixed field widths.
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;
  localparam int RESULT_W = 32;
  localparam int STATUS_W = 2;

  // Width that holds any table index or count for the full parameter range.
  localparam int EXT_W = 11;

  // Item functions.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_SPAN = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/pli_in_if.sv
`default_nettype none

interface pli_in_if #(
  parameter int DATA_WIDTH = pli_pkg::DEF_DATA_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic [pli_pkg::INDEX_W-1:0]       point_index;
  logic signed [DATA_WIDTH-1:0]      point_x;
  logic signed [DATA_WIDTH-1:0]      point_y;
  logic signed [DATA_WIDTH-1:0]      query_value;

  modport source (
    output valid, func, point_index, point_x, point_y, query_value,
    input  ready
  );

  modport sink (
    input  valid, func, point_index, point_x, point_y, query_value,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/pli_out_if.sv
`default_nettype none

interface pli_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pli_pkg::RESULT_W-1:0]  interp_result;
  logic [pli_pkg::STATUS_W-1:0]         status;

  modport source (
    output valid, interp_result, status,
    input  ready
  );

  modport sink (
    input  valid, interp_result, status,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/piecewise_linear_interpolator_core.sv
`default_nettype none

// Channel   Direction  Transfer when          Payload
// req       in         req.valid & req.ready  func, point_index, point_x, point_y, query_value
// rsp       out        rsp.valid & rsp.ready  interp_result, status
// cfg       in         cfg_we                 cfg_wdata (point_count)
//
// A load goes straight to the finishing state, which registers its result. A query
// runs a binary search with a SEARCH and a MID state per step on the single read
// port, then SEARCH, LO and HI for the lo and hi reads, a multiply and a sum state,
// 2*DATA_WIDTH+3 divider steps, then a saturation state and the finishing state
// that registers the output.
// Reset (rst, synchronous) clears point_count and the control state, not the table.
// A finished result waits while rsp stalls; the next item is taken once it moves.
module piecewise_linear_interpolator_core #(
  parameter int MAX_POINTS = pli_pkg::DEF_MAX_POINTS,
  parameter int DATA_WIDTH = pli_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pli_pkg::COUNT_W-1:0]   cfg_wdata,
  pli_in_if.sink                             req,
  pli_out_if.source                          rsp
);

  localparam int W   = DATA_WIDTH;
  localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int XW  = pli_pkg::EXT_W;
  localparam int CW  = pli_pkg::COUNT_W;
  localparam int NW  = 2 * W + 3;          // numerator width
  localparam int RW  = W + 2;              // divider remainder width
  localparam int DCW = $clog2(NW + 1);
  localparam int SW  = (NW + 1 > 33) ? NW + 1 : 33;
  localparam int RSW = pli_pkg::RESULT_W;

  localparam logic [XW-1:0] MAXP_EXT = XW'(MAX_POINTS);
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-64'sh0000_0000_8000_0000);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_MID    = 4'd2;
  localparam logic [3:0] S_LO     = 4'd3;
  localparam logic [3:0] S_HI     = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_FIX    = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0]                 state;
  logic [CW-1:0]              point_count;

  logic [2*W-1:0]             table_mem [MAX_POINTS];
  logic [2*W-1:0]             rd_data;
  logic [AW-1:0]              rd_addr;
  logic signed [W-1:0]        rd_x;
  logic signed [W-1:0]        rd_y;

  logic [CW-1:0]              lo;
  logic [CW-1:0]              hi;
  logic [CW-1:0]              mid;
  logic                       wide_gap;
  logic signed [W-1:0]        qv;
  logic signed [W-1:0]        xl;
  logic signed [W-1:0]        yl;
  logic signed [W:0]          dx;
  logic signed [W:0]          dy;
  logic signed [W:0]          dq;
  logic signed [W:0]          dx_next;
  logic signed [2*W:0]        prod_a;
  logic signed [2*W+1:0]      prod_b;
  logic signed [NW-1:0]       num_next;

  logic [NW-1:0]              quo;
  logic [RW-1:0]              rem;
  logic [W:0]                 dmag;
  logic                       neg;
  logic [DCW-1:0]             div_cnt;
  logic [RW-1:0]              rem_sh;
  logic signed [NW:0]         quo_s;
  logic signed [SW-1:0]       quo_ext;

  logic signed [RSW-1:0]      res;
  logic [pli_pkg::STATUS_W-1:0] res_status;
  logic                       out_valid;
  logic signed [RSW-1:0]      out_result;
  logic [pli_pkg::STATUS_W-1:0] out_status;

  logic [XW-1:0]              slot_ext;
  logic [XW-1:0]              cnt_ext;
  logic [XW-1:0]              n_ext;
  logic [XW-1:0]              addr_ext;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.interp_result = out_result;
  assign rsp.status        = out_status;

  assign rd_x = rd_data[2*W-1:W];
  assign rd_y = rd_data[W-1:0];

  assign slot_ext = XW'(req.point_index);
  assign cnt_ext  = XW'(point_count);
  assign n_ext    = (cnt_ext > MAXP_EXT) ? MAXP_EXT : cnt_ext;

  assign mid      = lo + ((hi - lo) >> 1);
  assign wide_gap = (hi - lo) > CW'(1);

  always_comb begin
    case (state)
      S_SEARCH: addr_ext = wide_gap ? XW'(mid) : XW'(lo);
      S_LO:     addr_ext = XW'(hi);
      default:  addr_ext = XW'(lo);
    endcase
  end
  assign rd_addr = addr_ext[AW-1:0];

  // Table memory: one write port used by loads, one registered read port
  // used by queries. Loads and queries never overlap, so no forwarding.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready && req.func == pli_pkg::FUNC_LOAD &&
        slot_ext < MAXP_EXT) begin
      table_mem[slot_ext[AW-1:0]] <= {req.point_x, req.point_y};
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  assign dx_next  = (W+1)'(rd_x) - (W+1)'(xl);
  assign num_next = NW'(prod_a) + NW'(prod_b);
  assign rem_sh   = {rem[RW-2:0], quo[NW-1]};
  assign quo_s    = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign quo_ext  = SW'(quo_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The finishing state handles the output register itself.
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res        <= '0;
            res_status <= pli_pkg::STATUS_OK;
            qv         <= req.query_value;
            lo         <= '0;
            hi         <= CW'(n_ext) - CW'(1);
            if (req.func == pli_pkg::FUNC_LOAD) begin
              state <= S_FINISH;
            end else if (n_ext < XW'(2)) begin
              res_status <= pli_pkg::STATUS_TOO_FEW;
              state      <= S_FINISH;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          state <= wide_gap ? S_MID : S_LO;
        end
        S_MID: begin
          if (qv < rd_x) begin
            hi <= mid;
          end else begin
            lo <= mid;
          end
          state <= S_SEARCH;
        end
        S_LO: begin
          xl    <= rd_x;
          yl    <= rd_y;
          state <= S_HI;
        end
        S_HI: begin
          dx <= dx_next;
          dy <= (W+1)'(rd_y) - (W+1)'(yl);
          dq <= (W+1)'(qv) - (W+1)'(xl);
          if (dx_next == '0) begin
            res_status <= pli_pkg::STATUS_ZERO_SPAN;
            state      <= S_FINISH;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod_a <= yl * dx;
          prod_b <= dy * dq;
          state  <= S_SUM;
        end
        S_SUM: begin
          quo     <= num_next[NW-1] ? NW'(-num_next) : NW'(num_next);
          neg     <= num_next[NW-1] ^ dx[W];
          dmag    <= dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
          rem     <= '0;
          div_cnt <= DCW'(NW);
          state   <= S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (rem_sh >= RW'(dmag)) begin
            rem <= rem_sh - RW'(dmag);
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[NW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == DCW'(1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          if (quo_ext > SAT_HI) begin
            res <= RSW'(SAT_HI);
          end else if (quo_ext < SAT_LO) begin
            res <= RSW'(SAT_LO);
          end else begin
            res <= RSW'(quo_ext);
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_result <= res;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The search window never collapses: lo stays strictly below hi.
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_MID) |-> (lo < hi))
    else $error("search window collapsed");

  // The divider leaves only after its last step.
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt != '0))
    else $error("divider ran past its last step");

  // A new result only appears out of the finishing state.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside the finishing state");

  // A finished result waits while the output register is still occupied.
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !rsp.ready) |=> (state == S_FINISH))
    else $error("result overwrote a pending output");

endmodule

`default_nettype wire

>>> test/pli_result_checker.sv
module pli_result_checker
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata,
  pli_in_if                       req,
  pli_out_if                      rsp,
  output int unsigned             mismatch_count,
  output int unsigned             results_outstanding
);

  localparam longint RESULT_MAX = 64'sd2147483647;
  localparam longint RESULT_MIN = -64'sd2147483648;
  localparam int     REPORT_LIMIT = 10;

  typedef struct packed {
    logic [RESULT_W-1:0] value;
    logic [STATUS_W-1:0] status;
  } interp_t;

  logic signed [DATA_WIDTH-1:0] knot_x [MAX_POINTS];
  logic signed [DATA_WIDTH-1:0] knot_y [MAX_POINTS];
  logic [COUNT_W-1:0]           point_count;
  interp_t                      expected_results [$];

  // Binary search for the bracketing segment, then the exact quotient of the
  // line through its two ends, truncated toward zero and clipped to 32 bits.
  function automatic interp_t interpolate_at(input logic signed [DATA_WIDTH-1:0] q);
    interp_t res;
    longint  n, lo, hi, mid, dx, dy, dq, quo;
    res.value  = '0;
    res.status = STATUS_OK;
    n = point_count;
    if (n > MAX_POINTS) n = MAX_POINTS;
    if (n < 2) begin
      res.status = STATUS_TOO_FEW;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (longint'(q) < longint'(knot_x[mid])) hi = mid;
        else lo = mid;
      end
      dx = longint'(knot_x[hi]) - longint'(knot_x[lo]);
      if (dx == 0) begin
        res.status = STATUS_ZERO_SPAN;
      end else begin
        dy  = longint'(knot_y[hi]) - longint'(knot_y[lo]);
        dq  = longint'(q) - longint'(knot_x[lo]);
        quo = (longint'(knot_y[lo]) * dx + dy * dq) / dx;
        if (quo > RESULT_MAX) quo = RESULT_MAX;
        else if (quo < RESULT_MIN) quo = RESULT_MIN;
        res.value = quo[RESULT_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    interp_t want;
    if (rst) begin
      point_count = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) point_count = cfg_wdata;
      // Results are retired before new requests are predicted, since a result
      // seen at this edge always belongs to an earlier transfer.
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: interp_result %0d status %0d",
                     $time, rsp.interp_result, rsp.status);
        end else begin
          want = expected_results.pop_front();
          if (rsp.interp_result !== want.value || rsp.status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch: interp_result %0d (expected %0d), status %0d (expected %0d)",
                       $time, rsp.interp_result, $signed(want.value), rsp.status,
                       want.status);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.func == FUNC_LOAD) begin
          if (int'(req.point_index) < MAX_POINTS) begin
            knot_x[req.point_index] = req.point_x;
            knot_y[req.point_index] = req.point_y;
          end
          want.value  = '0;
          want.status = STATUS_OK;
        end else begin
          want = interpolate_at(req.query_value);
        end
        expected_results.push_back(want);
      end
    end
    results_outstanding = expected_results.size();
  end

endmodule

>>> test/piecewise_linear_interpolator_core_tb.sv
module piecewise_linear_interpolator_core_tb;
  import pli_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int PHASE_ITEMS  = 600;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 150;
  localparam int NPTS         = DEF_MAX_POINTS;
  localparam int DW           = DEF_DATA_WIDTH;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  int unsigned        mismatch_count;
  int unsigned        results_outstanding;
  int unsigned        send_gap_pct = 19;
  int unsigned        stall_pct    = 86;
  int                 loaded_x [NPTS];

  pli_in_if  req_ch ();
  pli_out_if rsp_ch ();

  piecewise_linear_interpolator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  pli_result_checker result_check (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .req                 (req_ch),
    .rsp                 (rsp_ch),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int any_value();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Starts and ends on a falling edge; valid stays high into the next call.
  task automatic drive_request(input logic f, input int idx, input int x, input int y,
                               input int q);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= f;
    req_ch.point_index <= idx[INDEX_W-1:0];
    req_ch.point_x     <= x[DW-1:0];
    req_ch.point_y     <= y[DW-1:0];
    req_ch.query_value <= q[DW-1:0];
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_load(input int idx, input int x, input int y);
    loaded_x[idx] = x;
    drive_request(FUNC_LOAD, idx, x, y, any_value());
  endtask

  task automatic send_query(input int q);
    drive_request(FUNC_QUERY, $urandom_range(NPTS - 1), any_value(), any_value(), q);
  endtask

  // Always advances at least one falling edge, so valid is lowered only once.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (results_outstanding != 0);
  endtask

  task automatic set_point_count(input int value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[COUNT_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Loads slots 0..n-1 with ascending x, now and then with repeated x, and
  // sometimes with no order at all.
  task automatic fill_table(input int n);
    int span, cur, shape, x, y;
    span  = 65535 / n;
    shape = $urandom_range(9);
    cur   = $urandom_range(1) ? -32768 : -32768 + int'($urandom_range(span));
    for (int i = 0; i < n; i++) begin
      x = (shape == 0) ? any_value() : cur;
      y = (shape == 1) ? int'($urandom_range(200)) - 100 : any_value();
      send_load(i, x, y);
      if ($urandom_range(15) != 0) cur += int'($urandom_range(2 * span, 1));
      if (cur > 32767) cur = 32767;
    end
  endtask

  function automatic int pick_query(input int count);
    int n, v;
    n = (count > NPTS) ? NPTS : count;
    case ($urandom_range(9))
      0: v = -32768;
      1: v = 32767;
      2, 3, 4: begin
        v = (n < 2) ? any_value()
                    : loaded_x[$urandom_range(n - 1)] + int'($urandom_range(4)) - 2;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      default: v = any_value();
    endcase
    return v;
  endfunction

  // Ends the run when neither channel has moved a transfer for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int count, burst, sent, pick;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_LOAD;
    req_ch.point_index = '0;
    req_ch.point_x     = '0;
    req_ch.point_y     = '0;
    req_ch.query_value = '0;
    rsp_ch.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Too few points: the reset count of zero, then a single point.
    send_query(0);
    set_point_count(1);
    send_query(any_value());

    // Every slot is written once here, so no later search reads an empty one.
    fill_table(NPTS);

    set_point_count(2);
    send_load(0, -32768, -32768);
    send_load(1, 32767, 32767);
    send_query(-32768);
    send_query(32767);
    send_query(0);
    // Fractions of one third truncate toward zero on both sides of zero.
    send_load(0, 0, 0);
    send_load(1, 3, 1);
    send_query(-4);
    send_query(2);
    // A unit-wide segment extrapolated across the whole range saturates.
    send_load(0, -32768, -32768);
    send_load(1, -32767, 32767);
    send_query(32767);
    send_load(0, -32768, 32767);
    send_load(1, -32767, -32768);
    send_query(32767);
    send_load(1, -32768, 0);
    send_query(0);
    // Descending ends give a negative width.
    send_load(0, 100, 50);
    send_load(1, -100, -70);
    send_query(7);
    send_query(-32768);
    set_point_count(127);
    send_query(any_value());
    set_point_count(NPTS);
    send_query(pick_query(NPTS));

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 19;
          stall_pct    = 86;
        end
        1: begin
          send_gap_pct = 86;
          stall_pct    = 19;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          count = (pick < 3) ? $urandom_range(1) : $urandom_range(127, NPTS + 1);
        end else begin
          count = ($urandom_range(3) == 0) ? $urandom_range(NPTS, 2) : $urandom_range(8, 2);
          fill_table(count);
          sent += count;
        end
        set_point_count(count);
        burst = $urandom_range(20, 4);
        repeat (burst) begin
          if ($urandom_range(11) == 0)
            send_load($urandom_range(NPTS - 1), any_value(), any_value());
          else
            send_query(pick_query(count));
          sent++;
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
